### rtl/core/rtph264_pkg.sv
// ----------------------------------------------------------------------------
// rtph264_pkg
// Shared types and constants of the RTP H.264 depacketiser: channel payloads,
// the command passed from classifier to expander, and protocol codes.
// ----------------------------------------------------------------------------
package rtph264_pkg;

   // input transfer: one byte of an RTP packet
   typedef struct packed {
      logic [7:0] pkt_byte;
      logic       pkt_last;
   } req_type;

   // result transfer: one Annex-B stream byte or a unit mark
   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] out_kind;
      logic       run_last;
   } rsp_type;

   // work for the expander, taken in the order abandon, header, data, done
   typedef struct packed {
      logic       abandon;
      logic       header;
      logic       data;
      logic       done;
      logic [7:0] value;
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_UNDECIDED,
      KIND_SINGLE,
      KIND_FRAG,
      KIND_DROP
   } pkt_kind_type;

   // result kinds
   localparam logic [1:0] RES_DATA    = 2'd0;
   localparam logic [1:0] RES_DONE    = 2'd1;
   localparam logic [1:0] RES_ABANDON = 2'd2;

   // byte positions inside the packet
   localparam logic [3:0] POS_MARKER  = 4'd1;
   localparam logic [3:0] POS_NAL_HDR = 4'd12;
   localparam logic [3:0] POS_FU_HDR  = 4'd13;
   localparam logic [3:0] POS_PAYLOAD = 4'd14;

   // nal unit types
   localparam logic [4:0] NAL_SINGLE_MAX = 5'd23;
   localparam logic [4:0] NAL_FU_A       = 5'd28;

   // expander steps
   localparam int         STEP_W          = 3;
   localparam int         STEP_COUNT      = 8;
   localparam logic [2:0] STEP_ABANDON    = 3'd0;
   localparam logic [2:0] STEP_ZERO_A     = 3'd1;
   localparam logic [2:0] STEP_ZERO_B     = 3'd2;
   localparam logic [2:0] STEP_ZERO_C     = 3'd3;
   localparam logic [2:0] STEP_ONE        = 3'd4;
   localparam logic [2:0] STEP_NAL_HDR    = 3'd5;
   localparam logic [2:0] STEP_DATA       = 3'd6;
   localparam logic [2:0] STEP_DONE       = 3'd7;

   // command queue, depth a power of two
   localparam int CMD_DEPTH = 4;
   localparam int CMD_AW    = $clog2(CMD_DEPTH);
   localparam int CMD_CW    = $clog2(CMD_DEPTH + 1);

endpackage

### rtl/core/rtph264_front.sv
// ----------------------------------------------------------------------------
// rtph264_front
// Packet classifier: tracks the position in the RTP packet, decodes the NAL
// and FU headers; each accepted byte gives at most one expander command.
// ----------------------------------------------------------------------------
module rtph264_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  rtph264_pkg::req_type req_data,
   input  logic                 cmd_full,
   output logic                 cmd_push,
   output rtph264_pkg::cmd_type cmd
);

   logic [3:0]                byte_position_ff, byte_position_in;
   logic                      marker_seen_ff, marker_seen_in;
   rtph264_pkg::pkt_kind_type packet_kind_ff, packet_kind_in;
   logic                      assembling_ff, assembling_in;
   logic [7:0]                indicator_ff, indicator_in;
   logic                      accept;

   assign accept   = req_push && !cmd_full;
   assign cmd_push = accept && (cmd.abandon || cmd.header || cmd.data || cmd.done);

   always_comb begin
      logic [7:0] b;
      logic [4:0] nal_type;
      b                = req_data.pkt_byte;
      nal_type         = b[4:0];
      byte_position_in = byte_position_ff;
      marker_seen_in   = marker_seen_ff;
      packet_kind_in   = packet_kind_ff;
      assembling_in    = assembling_ff;
      indicator_in     = indicator_ff;
      cmd              = '0;
      cmd.value        = b;

      if (byte_position_ff == rtph264_pkg::POS_MARKER) begin
         marker_seen_in = b[7];
      end else if (byte_position_ff == rtph264_pkg::POS_NAL_HDR) begin
         if (nal_type != 5'd0 && nal_type <= rtph264_pkg::NAL_SINGLE_MAX) begin
            cmd.abandon    = assembling_ff;
            assembling_in  = 1'b0;
            cmd.header     = 1'b1;
            packet_kind_in = rtph264_pkg::KIND_SINGLE;
         end else if (nal_type == rtph264_pkg::NAL_FU_A) begin
            indicator_in   = b;
            packet_kind_in = rtph264_pkg::KIND_UNDECIDED;
         end else begin
            cmd.abandon    = assembling_ff;
            assembling_in  = 1'b0;
            packet_kind_in = rtph264_pkg::KIND_DROP;
         end
      end else if (byte_position_ff == rtph264_pkg::POS_FU_HDR) begin
         if (packet_kind_ff == rtph264_pkg::KIND_SINGLE) begin
            cmd.data = 1'b1;
         end else if (packet_kind_ff == rtph264_pkg::KIND_UNDECIDED) begin
            if (!marker_seen_ff && b[7]) begin
               // start fragment: rebuilt header from indicator f/nri and fu type
               cmd.abandon    = assembling_ff;
               cmd.header     = 1'b1;
               cmd.value      = {indicator_ff[7:5], b[4:0]};
               assembling_in  = 1'b1;
               packet_kind_in = rtph264_pkg::KIND_FRAG;
            end else begin
               packet_kind_in = assembling_ff ? rtph264_pkg::KIND_FRAG
                                              : rtph264_pkg::KIND_DROP;
            end
         end
      end else if (byte_position_ff >= rtph264_pkg::POS_PAYLOAD) begin
         if (packet_kind_ff == rtph264_pkg::KIND_SINGLE ||
             packet_kind_ff == rtph264_pkg::KIND_FRAG) begin
            cmd.data = 1'b1;
         end
      end

      if (req_data.pkt_last) begin
         if (packet_kind_in == rtph264_pkg::KIND_SINGLE) begin
            cmd.done = 1'b1;
         end else if (packet_kind_in == rtph264_pkg::KIND_FRAG && marker_seen_in &&
                      assembling_in) begin
            cmd.done      = 1'b1;
            assembling_in = 1'b0;
         end
         byte_position_in = 4'd0;
         marker_seen_in   = 1'b0;
         packet_kind_in   = rtph264_pkg::KIND_UNDECIDED;
      end else if (byte_position_ff < rtph264_pkg::POS_PAYLOAD) begin
         byte_position_in = byte_position_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff <= 4'd0;
         marker_seen_ff   <= 1'b0;
         packet_kind_ff   <= rtph264_pkg::KIND_UNDECIDED;
         assembling_ff    <= 1'b0;
         indicator_ff     <= 8'd0;
      end else if (accept) begin
         byte_position_ff <= byte_position_in;
         marker_seen_ff   <= marker_seen_in;
         packet_kind_ff   <= packet_kind_in;
         assembling_ff    <= assembling_in;
         indicator_ff     <= indicator_in;
      end
   end

endmodule

### rtl/core/rtph264_cmd_fifo.sv
// ----------------------------------------------------------------------------
// rtph264_cmd_fifo
// Short command queue between classifier and expander.
// ----------------------------------------------------------------------------
module rtph264_cmd_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rtph264_pkg::cmd_type push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 empty,
   output rtph264_pkg::cmd_type head
);

   rtph264_pkg::cmd_type               entry_ff [rtph264_pkg::CMD_DEPTH];
   logic [rtph264_pkg::CMD_AW-1:0]     wr_ptr_ff;
   logic [rtph264_pkg::CMD_AW-1:0]     rd_ptr_ff;
   logic [rtph264_pkg::CMD_CW-1:0]     count_ff;
   logic                               do_push;
   logic                               do_pop;

   assign full    = count_ff == rtph264_pkg::CMD_CW'(rtph264_pkg::CMD_DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

### rtl/core/rtph264_back.sv
// ----------------------------------------------------------------------------
// rtph264_back
// Result expander: walks the steps of the head command into a single output
// register, one result per cycle while that register can be written.
// ----------------------------------------------------------------------------
module rtph264_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_empty,
   input  rtph264_pkg::cmd_type cmd,
   output logic                 cmd_pop,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output rtph264_pkg::rsp_type rsp_data
);

   logic [rtph264_pkg::STEP_W-1:0]     step_ff;
   logic [rtph264_pkg::STEP_W-1:0]     cur;
   logic [rtph264_pkg::STEP_COUNT-1:0] mask;
   logic [rtph264_pkg::STEP_COUNT-1:0] upper;
   logic                               more;
   logic                               out_ready;
   logic                               emit;
   rtph264_pkg::rsp_type               result;
   rtph264_pkg::rsp_type               rsp_ff;
   logic                               rsp_valid_ff;

   assign mask = {cmd.done, cmd.data, {5{cmd.header}}, cmd.abandon};

   // lowest pending step at or after the current one
   always_comb begin
      cur = step_ff;
      for (int i = rtph264_pkg::STEP_COUNT - 1; i >= 0; i--) begin
         if (mask[i] && i >= int'(step_ff)) begin
            cur = rtph264_pkg::STEP_W'(i);
         end
      end
   end

   assign upper     = mask >> cur;
   assign more      = |upper[rtph264_pkg::STEP_COUNT-1:1];
   assign out_ready = !rsp_valid_ff || rsp_pop;
   assign emit      = !cmd_empty && out_ready;
   assign cmd_pop   = emit && !more;

   always_comb begin
      result          = '0;
      result.run_last = !more;
      unique case (cur)
         rtph264_pkg::STEP_ABANDON: begin
            result.out_kind = rtph264_pkg::RES_ABANDON;
         end
         rtph264_pkg::STEP_ZERO_A, rtph264_pkg::STEP_ZERO_B,
         rtph264_pkg::STEP_ZERO_C: begin
            result.out_kind = rtph264_pkg::RES_DATA;
         end
         rtph264_pkg::STEP_ONE: begin
            result.out_byte = 8'd1;
            result.out_kind = rtph264_pkg::RES_DATA;
         end
         rtph264_pkg::STEP_NAL_HDR, rtph264_pkg::STEP_DATA: begin
            result.out_byte = cmd.value;
            result.out_kind = rtph264_pkg::RES_DATA;
         end
         rtph264_pkg::STEP_DONE: begin
            result.out_kind = rtph264_pkg::RES_DONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= rtph264_pkg::STEP_ABANDON;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit) begin
            step_ff      <= more ? cur + 1'b1 : rtph264_pkg::STEP_ABANDON;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### rtl/core/rtp_h264_depacketizer.sv
// ----------------------------------------------------------------------------
// rtp_h264_depacketizer
// RTP H.264 depacketiser: single NAL units and FU-A fragments to Annex-B.
// ----------------------------------------------------------------------------
// usage
//  - request side is a queue write port: a byte transfer happens when req_push
//    is high and req_full low; pkt_last marks the final byte of a packet
//  - response side is a queue read port: rsp_data holds the oldest result while
//    rsp_empty is low, rsp_pop takes it; run_last flags the last result of a byte
//  - flow: a byte's command enters the command queue at its transfer; the
//    expander then puts its first result into the output register (rsp_data)
//  - throughput: one byte per cycle while every byte yields at most one result
//    (payload); the expander emits one result per unstalled cycle, so a header
//    byte that yields up to seven results holds the expander until all are out
//  - a four-entry command queue absorbs these bursts; req_full rises only when
//    it is full
//  - when the receiver stalls, the output register holds, the expander stops
//    and the command queue fills, then req_full stalls the sender
//  - reset (synchronous) empties the queue and output register, and clears the
//    packet position, marker, packet kind, open-unit flag and fu indicator
// ----------------------------------------------------------------------------
module rtp_h264_depacketizer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  rtph264_pkg::req_type req_data,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output rtph264_pkg::rsp_type rsp_data
);

   // commands from classifier into the queue
   rtph264_pkg::cmd_type cmd_in;
   logic                 cmd_push;
   logic                 cmd_full;

   // head of the queue into the expander
   rtph264_pkg::cmd_type cmd_head;
   logic                 cmd_empty;
   logic                 cmd_pop;

   // the sender stalls only on a full command queue
   assign req_full = cmd_full;

   // front: position tracking and header decoding
   rtph264_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .cmd_full (cmd_full),
      .cmd_push (cmd_push),
      .cmd      (cmd_in)
   );

   // decoupling queue
   rtph264_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .empty     (cmd_empty),
      .head      (cmd_head)
   );

   // back: expand commands into result transfers
   rtph264_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd       (cmd_head),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

### tb/rtp_h264_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rtp_h264_checker
// Watches both channels of the depacketiser, predicts the Annex-B stream from
// the accepted packet bytes and compares every result transfer in order.
// ----------------------------------------------------------------------------
module rtp_h264_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  logic                 req_full,
   input  rtph264_pkg::req_type req_data,
   input  logic                 rsp_empty,
   input  logic                 rsp_pop,
   input  rtph264_pkg::rsp_type rsp_data,
   output int                   errors,
   output int                   outstanding
);

   // predicted stream, oldest first
   rtph264_pkg::rsp_type      stream_q [$];

   // predictor state
   logic [3:0]                byte_pos;
   logic                      marker;
   rtph264_pkg::pkt_kind_type kind;
   logic                      unit_open;
   logic [7:0]                indicator_hold;

   // results caused by the byte being predicted
   rtph264_pkg::rsp_type      burst [8];
   int                        burst_len;

   task automatic emit(input logic [7:0] value, input logic [1:0] res_kind);
      rtph264_pkg::rsp_type r;
      r.out_byte = value;
      r.out_kind = res_kind;
      r.run_last = 1'b0;
      burst[burst_len] = r;
      burst_len++;
   endtask

   task automatic emit_unit_start(input logic [7:0] nal_byte);
      emit(8'h00, rtph264_pkg::RES_DATA);
      emit(8'h00, rtph264_pkg::RES_DATA);
      emit(8'h00, rtph264_pkg::RES_DATA);
      emit(8'h01, rtph264_pkg::RES_DATA);
      emit(nal_byte, rtph264_pkg::RES_DATA);
   endtask

   task automatic abandon_unit();
      if (unit_open) begin
         emit(8'h00, rtph264_pkg::RES_ABANDON);
         unit_open = 1'b0;
      end
   endtask

   task automatic predict_stream(input rtph264_pkg::req_type item);
      logic [7:0] b;
      logic [4:0] nal_type;
      b        = item.pkt_byte;
      nal_type = b[4:0];
      burst_len = 0;
      if (byte_pos == rtph264_pkg::POS_MARKER) begin
         marker = b[7];
      end else if (byte_pos == rtph264_pkg::POS_NAL_HDR) begin
         if (nal_type >= 5'd1 && nal_type <= rtph264_pkg::NAL_SINGLE_MAX) begin
            abandon_unit();
            emit_unit_start(b);
            kind = rtph264_pkg::KIND_SINGLE;
         end else if (nal_type == rtph264_pkg::NAL_FU_A) begin
            indicator_hold = b;
            kind           = rtph264_pkg::KIND_UNDECIDED;
         end else begin
            abandon_unit();
            kind = rtph264_pkg::KIND_DROP;
         end
      end else if (byte_pos == rtph264_pkg::POS_FU_HDR) begin
         if (kind == rtph264_pkg::KIND_SINGLE) begin
            emit(b, rtph264_pkg::RES_DATA);
         end else if (kind == rtph264_pkg::KIND_UNDECIDED) begin
            if (marker || !b[7]) begin
               kind = unit_open ? rtph264_pkg::KIND_FRAG : rtph264_pkg::KIND_DROP;
            end else begin
               abandon_unit();
               emit_unit_start({indicator_hold[7:5], b[4:0]});
               unit_open = 1'b1;
               kind      = rtph264_pkg::KIND_FRAG;
            end
         end
      end else if (byte_pos >= rtph264_pkg::POS_PAYLOAD) begin
         if (kind == rtph264_pkg::KIND_SINGLE || kind == rtph264_pkg::KIND_FRAG)
            emit(b, rtph264_pkg::RES_DATA);
      end

      if (item.pkt_last) begin
         if (kind == rtph264_pkg::KIND_SINGLE) begin
            emit(8'h00, rtph264_pkg::RES_DONE);
         end else if (kind == rtph264_pkg::KIND_FRAG && marker && unit_open) begin
            emit(8'h00, rtph264_pkg::RES_DONE);
            unit_open = 1'b0;
         end
         byte_pos = '0;
         marker   = 1'b0;
         kind     = rtph264_pkg::KIND_UNDECIDED;
      end else if (byte_pos < rtph264_pkg::POS_PAYLOAD) begin
         byte_pos = byte_pos + 4'd1;
      end

      if (burst_len > 0)
         burst[burst_len - 1].run_last = 1'b1;
      for (int i = 0; i < burst_len; i++)
         stream_q.push_back(burst[i]);
   endtask

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("%0t ns mismatch: %s got %0h expected %0h", $time, what, got, want);
      errors++;
   endtask

   task automatic check_result(input rtph264_pkg::rsp_type got);
      rtph264_pkg::rsp_type want;
      if (stream_q.size() == 0) begin
         report_mismatch("result with nothing expected, out_byte", got.out_byte, 8'h00);
      end else begin
         want = stream_q.pop_front();
         if (got.out_byte !== want.out_byte)
            report_mismatch("out_byte", got.out_byte, want.out_byte);
         if (got.out_kind !== want.out_kind)
            report_mismatch("out_kind", {6'd0, got.out_kind}, {6'd0, want.out_kind});
         if (got.run_last !== want.run_last)
            report_mismatch("run_last", {7'd0, got.run_last}, {7'd0, want.run_last});
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         byte_pos       = '0;
         marker         = 1'b0;
         kind           = rtph264_pkg::KIND_UNDECIDED;
         unit_open      = 1'b0;
         indicator_hold = '0;
         stream_q.delete();
         errors         = 0;
      end else begin
         if (rsp_pop && !rsp_empty)
            check_result(rsp_data);
         if (req_push && !req_full)
            predict_stream(req_data);
      end
      outstanding = stream_q.size();
   end

endmodule

### tb/tb_rtp_h264_depacketizer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rtp_h264_depacketizer
// Regression for the RTP H.264 depacketiser: in each of several sender and
// receiver idling mixes, directed packets (single NAL units, FU-A reassembly,
// drops and short packets) followed by random packet traffic. A checker beside
// the block predicts and compares the stream; this module drives and decides.
// ----------------------------------------------------------------------------
module tb_rtp_h264_depacketizer;

   localparam int WATCHDOG_LIMIT = 5000;   // cycles with no transfer at all
   localparam int DRAIN_CYCLES   = 16;     // settle time after the last result
   localparam int PHASE_ITEMS    = 70;     // byte transfers per phase

   // nal unit types used by the directed and random parts
   localparam logic [4:0] NAL_UNSPECIFIED = 5'd0;
   localparam logic [4:0] NAL_SLICE       = 5'd1;
   localparam logic [4:0] NAL_IDR         = 5'd5;
   localparam logic [4:0] NAL_SPS         = 5'd7;
   localparam logic [4:0] NAL_STAP_A      = 5'd24;
   localparam logic [4:0] NAL_FU_B        = 5'd29;
   localparam logic [4:0] NAL_RESERVED_31 = 5'd31;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_push  = 1'b0;
   logic                 req_full;
   rtph264_pkg::req_type req_data  = '0;
   logic                 rsp_empty;
   logic                 rsp_pop   = 1'b0;
   rtph264_pkg::rsp_type rsp_data;

   int mismatch_count;
   int pending_results;

   // idling mix, percent of cycles
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   // byte transfers sent so far
   int items_sent = 0;

   always #5 clock = ~clock;

   rtp_h264_depacketizer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   rtp_h264_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data),
      .errors      (mismatch_count),
      .outstanding (pending_results)
   );

   // receiver: pop on the falling edge, stalling at the current rate
   always @(negedge clock) begin
      rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
   end

   // watchdog: any transfer or reset restarts the count
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty))
            quiet = 0;
         else
            quiet++;
      end
      $display("rtp_h264_depacketizer regression: fail");
      $finish;
   end

   // payload byte, with the extremes turning up often
   function automatic logic [7:0] pick_byte();
      logic [7:0] value;
      case ($urandom_range(7))
         0:       value = 8'h00;
         1:       value = 8'hFF;
         default: value = 8'($urandom_range(255));
      endcase
      return value;
   endfunction

   // nal header (or fu indicator) with random forbidden bit and nri
   function automatic logic [7:0] nal_hdr(input logic [4:0] nal_type);
      logic [2:0] f_nri;
      f_nri = 3'($urandom_range(7));
      return {f_nri, nal_type};
   endfunction

   // fu header: start, end, reserved bit random, original type
   function automatic logic [7:0] fu_hdr(input logic s, input logic e,
                                         input logic [4:0] nal_type);
      logic r;
      r = 1'($urandom_range(1));
      return {s, e, r, nal_type};
   endfunction

   // mostly short payloads, now and then long enough to saturate the position
   function automatic int payload_len();
      if ($urandom_range(9) == 0)
         return $urandom_range(20);
      return $urandom_range(4);
   endfunction

   // a type that is neither single nal nor fu-a
   function automatic logic [4:0] other_type();
      int pick;
      pick = $urandom_range(7);
      if (pick == 0)
         return NAL_UNSPECIFIED;
      else if (pick <= 4)
         return 5'(NAL_STAP_A + pick - 1);
      return 5'(NAL_FU_B + pick - 5);
   endfunction

   // one byte transfer; called and returning on a falling edge
   task automatic send_byte(input logic [7:0] value, input logic last);
      rtph264_pkg::req_type item;
      item.pkt_byte = value;
      item.pkt_last = last;
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      @(negedge clock);
   endtask

   // whole rtp packet: random 12-byte header with the marker, nal header,
   // fu header for fu-a, payload; cut_len > 0 truncates the packet
   task automatic send_packet(input logic marker, input logic [7:0] nal_byte,
                              input logic [7:0] fu_byte, input int pay_len,
                              input int cut_len);
      logic [7:0] pkt [64];
      int         len;
      int         hdr_len;
      hdr_len = (nal_byte[4:0] == rtph264_pkg::NAL_FU_A) ? 14 : 13;
      len     = hdr_len + pay_len;
      if (cut_len > 0 && cut_len < len)
         len = cut_len;
      for (int i = 0; i < 12; i++)
         pkt[i] = 8'($urandom_range(255));
      pkt[1][7] = marker;
      pkt[12]   = nal_byte;
      pkt[13]   = fu_byte;
      for (int i = hdr_len; i < len; i++)
         pkt[i] = pick_byte();
      for (int i = 0; i < len; i++) begin
         send_byte(pkt[i], i == len - 1);
         items_sent++;
      end
   endtask

   // single nal units, then a whole fu-a unit whose position saturates
   task automatic directed_units();
      send_packet(1'b1, nal_hdr(NAL_SLICE), 8'h00, 2, 0);
      send_packet(1'b0, nal_hdr(rtph264_pkg::NAL_SINGLE_MAX), 8'h00, 0, 0);
      send_packet(1'b0, 8'hFC, fu_hdr(1'b1, 1'b0, NAL_IDR), 1, 0);
      send_packet(1'b0, 8'h1C, fu_hdr(1'b0, 1'b0, NAL_IDR), 3, 0);
      send_packet(1'b1, nal_hdr(rtph264_pkg::NAL_FU_A), fu_hdr(1'b0, 1'b1, NAL_IDR), 0, 0);
   endtask

   // start over an open unit abandons it, as does a single nal unit
   task automatic directed_abandon();
      send_packet(1'b0, nal_hdr(rtph264_pkg::NAL_FU_A), fu_hdr(1'b1, 1'b0, 5'd31), 0, 0);
      send_packet(1'b0, nal_hdr(rtph264_pkg::NAL_FU_A), fu_hdr(1'b1, 1'b0, 5'd0), 0, 0);
      send_packet(1'b0, nal_hdr(NAL_SPS), 8'h00, 0, 0);
   endtask

   // stray fragments with no unit open, and a marker-1 start
   task automatic directed_stray();
      send_packet(1'b1, nal_hdr(NAL_SLICE), 8'h00, 0, 0);
      send_packet(1'b0, nal_hdr(rtph264_pkg::NAL_FU_A), fu_hdr(1'b0, 1'b0, NAL_SLICE), 0, 0);
      send_packet(1'b1, nal_hdr(rtph264_pkg::NAL_FU_A), fu_hdr(1'b0, 1'b1, NAL_SLICE), 0, 0);
      send_packet(1'b1, nal_hdr(rtph264_pkg::NAL_FU_A), fu_hdr(1'b1, 1'b1, NAL_SLICE), 0, 0);
   endtask

   // short packets leave the open unit alone, an unlisted type drops it, and
   // a marker-1 start fragment with a unit open completes it
   task automatic directed_short_drop();
      send_packet(1'b0, nal_hdr(rtph264_pkg::NAL_FU_A), fu_hdr(1'b1, 1'b0, NAL_SLICE), 0, 0);
      send_packet(1'b0, nal_hdr(NAL_SLICE), 8'h00, 2, 1);
      send_packet(1'b1, nal_hdr(NAL_SLICE), 8'h00, 2, 6);
      send_packet(1'b1, nal_hdr(rtph264_pkg::NAL_FU_A), fu_hdr(1'b0, 1'b1, NAL_SLICE), 2, 13);
      send_packet(1'b0, nal_hdr(NAL_RESERVED_31), 8'h00, 0, 0);
      send_packet(1'b0, nal_hdr(rtph264_pkg::NAL_FU_A), fu_hdr(1'b1, 1'b0, NAL_IDR), 0, 0);
      send_packet(1'b1, nal_hdr(rtph264_pkg::NAL_FU_A), fu_hdr(1'b1, 1'b1, NAL_IDR), 1, 0);
   endtask

   task automatic random_traffic(input int target);
      int         pick;
      int         frags;
      logic [4:0] frag_type;
      while (items_sent < target) begin
         pick = $urandom_range(99);
         if (pick < 35) begin
            // well-formed fu-a unit with random content
            frag_type = 5'($urandom_range(31));
            frags     = $urandom_range(3);
            send_packet(1'b0, nal_hdr(rtph264_pkg::NAL_FU_A),
                        fu_hdr(1'b1, 1'b0, frag_type), payload_len(), 0);
            repeat (frags)
               send_packet(1'b0, nal_hdr(rtph264_pkg::NAL_FU_A),
                           fu_hdr(1'b0, 1'b0, frag_type), payload_len(), 0);
            send_packet(1'b1, nal_hdr(rtph264_pkg::NAL_FU_A),
                        fu_hdr(1'b0, 1'b1, frag_type), payload_len(), 0);
         end else if (pick < 65) begin
            send_packet(1'($urandom_range(1)),
                        nal_hdr(5'($urandom_range(rtph264_pkg::NAL_SINGLE_MAX, 1))),
                        8'h00, payload_len(), 0);
         end else begin
            case ($urandom_range(5))
               // fragment with any fu header: stray, start, or end
               0: send_packet(1'($urandom_range(1)), nal_hdr(rtph264_pkg::NAL_FU_A),
                              8'($urandom_range(255)), payload_len(), 0);
               1: send_packet(1'($urandom_range(1)), nal_hdr(other_type()), pick_byte(),
                              payload_len(), 0);
               // ends inside the rtp header
               2: send_packet(1'($urandom_range(1)), 8'($urandom_range(255)),
                              8'($urandom_range(255)), payload_len(),
                              $urandom_range(12, 1));
               // fu-a ending before its fu header
               3: send_packet(1'($urandom_range(1)), nal_hdr(rtph264_pkg::NAL_FU_A),
                              8'($urandom_range(255)), payload_len(), 13);
               // start that is never finished
               4: send_packet(1'b0, nal_hdr(rtph264_pkg::NAL_FU_A),
                              fu_hdr(1'b1, 1'($urandom_range(1)), 5'($urandom_range(31))),
                              payload_len(), 0);
               default: send_packet(1'($urandom_range(1)), 8'($urandom_range(255)),
                                    8'($urandom_range(255)), payload_len(), 0);
            endcase
         end
      end
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // no idling
      directed_units();
      random_traffic(PHASE_ITEMS);
      // sender idle
      send_idle_pct  = 68;
      directed_abandon();
      random_traffic(2 * PHASE_ITEMS);
      // receiver stalling
      send_idle_pct  = 0;
      recv_stall_pct = 68;
      directed_stray();
      random_traffic(3 * PHASE_ITEMS);
      // both
      send_idle_pct  = 37;
      recv_stall_pct = 37;
      directed_short_drop();
      random_traffic(4 * PHASE_ITEMS);

      // drain: no more transfers in, wait for every expected result
      req_push <= 1'b0;
      recv_stall_pct = 0;
      while (pending_results != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0)
         $display("rtp_h264_depacketizer regression: pass");
      else
         $display("rtp_h264_depacketizer regression: fail");
      $finish;
   end

endmodule
